/* design/psita_pkg.sv */
// ----------------------------------------------------------------------------
// psita_pkg
// Types and constants shared by the PSI table section assembler.
// ----------------------------------------------------------------------------
package psita_pkg;

    localparam int MAX_SECTIONS = 256;
    localparam int SEC_IDX_W    = $clog2(MAX_SECTIONS);
    localparam int SEC_W        = 8;
    localparam int CNT_W        = 9;
    localparam int CFG_IDX_W    = 1;

    localparam logic [SEC_W-1:0] RESET_TABLE_ID = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_REPLACE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_GROW    = 1'b1;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_REPLACED = 3'd1,
        ST_INVALID  = 3'd2,
        ST_OTHER    = 3'd3,
        ST_SIZE     = 3'd4,
        ST_DUP      = 3'd5,
        ST_CLEARED  = 3'd6
    } t_status;

    typedef struct packed {
        logic             mode;
        logic             section_ok;
        logic [7:0]       table_id;
        logic [15:0]      table_id_ext;
        logic [4:0]       version_number;
        logic [SEC_W-1:0] section_number;
        logic [SEC_W-1:0] last_section_number;
    } t_in;

    typedef struct packed {
        logic             accepted;
        t_status          status;
        logic             table_complete;
        logic [CNT_W-1:0] missing_sections;
        logic [SEC_W-1:0] table_last_section;
        logic [SEC_W-1:0] adjusted_last_section;
    } t_out;

    typedef struct packed {
        logic allow_replace;
        logic allow_grow;
    } t_cfg;

endpackage

/* design/psita_core.sv */
// ----------------------------------------------------------------------------
// psita_core
// Table state (identity, size, missing count, presence map) and the
// combinational section check and the registered update. The presence map
// is a memory read with registered data when an item is loaded, and zeroed
// one entry per cycle after reset and after a clear.
// ----------------------------------------------------------------------------
module psita_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  psita_pkg::t_in                  i_item,
    input  psita_pkg::t_cfg                 i_cfg,
    input  logic                            i_load,
    input  logic [psita_pkg::SEC_IDX_W-1:0] i_load_idx,
    output logic                            o_busy,
    output psita_pkg::t_out                 o_res
);
    import psita_pkg::*;

    localparam logic [CNT_W-1:0] MAX_SEC_CNT = CNT_W'(MAX_SECTIONS);

    logic                    r_mem [MAX_SECTIONS];
    logic                    r_present;
    logic                    r_busy;
    logic [SEC_IDX_W-1:0]    r_clr_addr;
    logic [7:0]              r_tid;
    logic [15:0]             r_ext;
    logic [4:0]              r_ver;
    logic [CNT_W-1:0]        r_size;
    logic [CNT_W-1:0]        r_missing;
    logic                    r_complete;

    logic [CNT_W-1:0]        n_size;
    logic [CNT_W-1:0]        n_missing;
    logic                    n_complete;
    logic                    n_map_set;
    logic                    n_take_id;
    logic                    n_commit;

    logic [SEC_IDX_W-1:0]    w_idx;
    logic [CNT_W-1:0]        w_lsn;
    logic [CNT_W-1:0]        w_size_new;
    logic [CNT_W-1:0]        w_grown;
    logic [CNT_W-1:0]        w_size_m1;
    logic                    w_empty;
    logic                    w_invalid;
    logic                    w_other;
    logic                    w_size_diff;
    logic                    w_present;
    logic                    w_bypass;
    logic                    w_clr_last;
    t_status                 w_status;

    assign o_busy     = r_busy;
    assign w_bypass   = i_step && n_map_set && (w_idx == i_load_idx);
    assign w_clr_last = (r_clr_addr == SEC_IDX_W'(MAX_SECTIONS - 1));

    always_comb begin
        w_idx       = i_item.section_number[SEC_IDX_W-1:0];
        w_lsn       = {1'b0, i_item.last_section_number};
        w_size_new  = w_lsn + CNT_W'(1);
        w_empty     = (r_size == '0);
        w_invalid   = !i_item.section_ok
                      || (i_item.section_number > i_item.last_section_number)
                      || (w_lsn >= MAX_SEC_CNT);
        w_other     = !w_empty && ((i_item.table_id != r_tid)
                      || (i_item.table_id_ext != r_ext)
                      || (i_item.version_number != r_ver));
        w_size_diff = !w_empty && (w_size_new != r_size);
        w_present   = r_present;
        w_grown     = r_missing + w_size_new - r_size;

        n_size      = r_size;
        n_missing   = r_missing;
        n_complete  = r_complete;
        n_map_set   = 1'b0;
        n_take_id   = 1'b0;
        n_commit    = 1'b0;
        w_status    = ST_ADDED;

        priority if (i_item.mode) begin
            w_status   = ST_CLEARED;
            n_size     = '0;
            n_missing  = '0;
            n_complete = 1'b0;
        end else if (w_invalid) begin
            w_status = ST_INVALID;
        end else if (w_other) begin
            w_status = ST_OTHER;
        end else if (w_size_diff && !i_cfg.allow_grow) begin
            w_status = ST_SIZE;
        end else begin
            n_commit = 1'b1;
            if (w_empty) begin
                n_take_id = 1'b1;
                n_size    = w_size_new;
                n_missing = w_size_new;
            end else if (w_size_diff && (w_size_new > r_size)) begin
                n_size    = w_size_new;
                n_missing = w_grown;
            end
            if (!w_present) begin
                n_map_set = 1'b1;
                n_missing = n_missing - CNT_W'(1);
                w_status  = ST_ADDED;
            end else if (i_cfg.allow_replace) begin
                w_status = ST_REPLACED;
            end else begin
                w_status = ST_DUP;
            end
            n_complete = (n_missing == '0);
        end

        w_size_m1 = n_size - CNT_W'(1);

        o_res.accepted              = (w_status == ST_ADDED) || (w_status == ST_REPLACED);
        o_res.status                = w_status;
        o_res.table_complete        = n_complete;
        o_res.missing_sections      = n_missing;
        o_res.table_last_section    = (n_size == '0) ? '0 : w_size_m1[SEC_W-1:0];
        o_res.adjusted_last_section = o_res.accepted ? w_size_m1[SEC_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_step && n_map_set) begin
            r_mem[w_idx] <= 1'b1;
        end
        if (i_load) begin
            r_present <= w_bypass ? 1'b1 : r_mem[i_load_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + SEC_IDX_W'(1);
            if (w_clr_last) begin
                r_busy <= 1'b0;
            end
        end else if (i_step && i_item.mode) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tid      <= RESET_TABLE_ID;
            r_ext      <= '0;
            r_ver      <= '0;
            r_size     <= '0;
            r_missing  <= '0;
            r_complete <= 1'b0;
        end else if (i_step) begin
            r_size     <= n_size;
            r_missing  <= n_missing;
            r_complete <= n_complete;
            if (i_item.mode) begin
                r_tid <= RESET_TABLE_ID;
                r_ext <= '0;
                r_ver <= '0;
            end else if (n_commit) begin
                if (n_take_id) begin
                    r_tid <= i_item.table_id;
                    r_ext <= i_item.table_id_ext;
                    r_ver <= i_item.version_number;
                end
            end
        end
    end

endmodule

/* design/psi_table_section_assembler_top.sv */
// ----------------------------------------------------------------------------
// psi_table_section_assembler_top
// Tracks the assembly of one PSI table from its section headers.
//
//   channel   signals                                       direction
//   in        i_in_valid / o_in_ready / i_in_data           section or clear
//   out       o_out_valid / i_out_ready / o_out_data        one result each
//   cfg       i_cfg_valid / o_cfg_ready / i_cfg_index,data  register write
//
// One section per cycle unless the output stalls or the map is being zeroed;
// a beat is registered at input, then its result in the result register.
// The table update runs between the input register and the result register.
// Reset starts a pass that zeroes the 256-entry presence map one entry per
// cycle; the input opens when the pass ends.
// A clear holds the input off through its update and the pass that follows.
// A stalled result holds both registers; outside these, the input takes a new
// beat whenever its register is empty or moves on.
// ----------------------------------------------------------------------------
module psi_table_section_assembler_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  psita_pkg::t_in                 i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output psita_pkg::t_out                o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [psita_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                           i_cfg_data
);
    import psita_pkg::*;

    logic r_in_vld;
    t_in  r_in;
    logic r_out_vld;
    t_out r_out;
    t_cfg r_cfg;

    logic w_adv;
    logic w_step;
    logic w_load;
    logic w_busy;
    t_out w_res;

    assign w_adv       = !r_out_vld || i_out_ready;
    assign w_step      = r_in_vld && w_adv;
    assign o_in_ready  = !w_busy && !(w_step && r_in.mode) && (!r_in_vld || w_adv);
    assign w_load      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    psita_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_item     (r_in),
        .i_cfg      (r_cfg),
        .i_load     (w_load),
        .i_load_idx (i_in_data.section_number[SEC_IDX_W-1:0]),
        .o_busy     (w_busy),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end else if (w_step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ALLOW_REPLACE: begin
                    r_cfg.allow_replace <= i_cfg_data;
                end
                CFG_ALLOW_GROW: begin
                    r_cfg.allow_grow <= i_cfg_data;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> (r_in_vld && $stable(r_in)))
        else $error("input register lost a waiting beat");

    a_accept_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.accepted ==
            ((r_out.status == ST_ADDED) || (r_out.status == ST_REPLACED))))
        else $error("accepted flag disagrees with status");

    a_complete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.table_complete) |-> (r_out.missing_sections == '0))
        else $error("table complete with sections missing");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.status == ST_CLEARED)) |->
            ((r_out.missing_sections == '0) && (r_out.table_last_section == '0)
             && !r_out.table_complete))
        else $error("clear left table state behind");

    a_no_step_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_step)
        else $error("table step while presence map is being zeroed");
`endif

endmodule

/* bench/psi_table_section_assembler_top_tb.sv */
// ----------------------------------------------------------------------------
// psi_table_section_assembler_top_tb
// Self-checking bench for the PSI table section assembler. A behavioral table
// tracker predicts one verdict per input beat. A checker compares every
// result beat field by field in order. Directed cases cover identity, size,
// grow and replace rules, then one long output stall. Random table episodes
// under all register settings follow, with random idling on both sides.
// ----------------------------------------------------------------------------
module psi_table_section_assembler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psita_pkg::*;

    localparam int RUN_LIMIT_NS = 20_000_000;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    t_in                  in_data     = '0;
    logic                 out_ready   = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_ALLOW_REPLACE;
    logic                 cfg_data    = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out                 o_out_data;
    logic                 o_cfg_ready;

    logic [MAX_SECTIONS-1:0] tbl_present;
    logic [7:0]              tbl_id;
    logic [15:0]             tbl_ext;
    logic [4:0]              tbl_ver;
    logic [8:0]              tbl_size;
    logic [8:0]              tbl_missing;
    logic                    tbl_complete;
    logic                    cfg_replace;
    logic                    cfg_grow;

    t_out verdict_q[$];
    t_out want;
    int   n_fail  = 0;
    bit   tx_idle = 1'b1;
    bit   rx_idle = 1'b1;
    int   rx_hold = 0;

    psi_table_section_assembler_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic void forget_table();
        tbl_present  = '0;
        tbl_id       = RESET_TABLE_ID;
        tbl_ext      = '0;
        tbl_ver      = '0;
        tbl_size     = '0;
        tbl_missing  = '0;
        tbl_complete = 1'b0;
    endfunction

    function automatic t_status table_add(input t_in it, output logic [7:0] adj);
        logic [8:0] new_size;
        adj = '0;
        new_size = {1'b0, it.last_section_number} + 9'd1;
        if (!it.section_ok || it.section_number > it.last_section_number ||
            int'(it.last_section_number) >= MAX_SECTIONS)
            return ST_INVALID;
        if (tbl_size == 9'd0) begin
            tbl_size    = new_size;
            tbl_id      = it.table_id;
            tbl_ext     = it.table_id_ext;
            tbl_ver     = it.version_number;
            tbl_missing = new_size;
        end else if (it.table_id != tbl_id || it.table_id_ext != tbl_ext ||
                     it.version_number != tbl_ver) begin
            return ST_OTHER;
        end else if (new_size != tbl_size) begin
            if (!cfg_grow)
                return ST_SIZE;
            if (new_size > tbl_size) begin
                tbl_missing = tbl_missing + new_size - tbl_size;
                tbl_size    = new_size;
            end
        end
        if (!tbl_present[it.section_number]) begin
            tbl_present[it.section_number] = 1'b1;
            tbl_missing  = tbl_missing - 9'd1;
            tbl_complete = (tbl_missing == 9'd0);
            adj = 8'(tbl_size - 9'd1);
            return ST_ADDED;
        end
        tbl_complete = (tbl_missing == 9'd0);
        if (!cfg_replace)
            return ST_DUP;
        adj = 8'(tbl_size - 9'd1);
        return ST_REPLACED;
    endfunction

    function automatic t_out assemble_section(input t_in it);
        t_out       r;
        logic [7:0] adj;
        r   = '0;
        adj = '0;
        if (it.mode) begin
            forget_table();
            r.status = ST_CLEARED;
        end else begin
            r.status = table_add(it, adj);
        end
        r.accepted              = (r.status == ST_ADDED) || (r.status == ST_REPLACED);
        r.table_complete        = tbl_complete;
        r.missing_sections      = tbl_missing;
        r.table_last_section    = (tbl_size == 9'd0) ? 8'd0 : 8'(tbl_size - 9'd1);
        r.adjusted_last_section = adj;
        return r;
    endfunction

    function automatic t_in make_section(input logic ok, input logic [7:0] tid,
                                         input logic [15:0] ext, input logic [4:0] ver,
                                         input logic [7:0] sn, input logic [7:0] lsn);
        t_in it;
        it.mode                = 1'b0;
        it.section_ok          = ok;
        it.table_id            = tid;
        it.table_id_ext        = ext;
        it.version_number      = ver;
        it.section_number      = sn;
        it.last_section_number = lsn;
        return it;
    endfunction

    function automatic t_in random_item(input logic mode);
        logic [63:0] r64;
        t_in         it;
        r64     = {$urandom(), $urandom()};
        it      = r64[$bits(t_in)-1:0];
        it.mode = mode;
        return it;
    endfunction

    task automatic send_item(input t_in it);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (o_in_ready !== 1'b1) @(posedge clk);
        verdict_q.push_back(assemble_section(it));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic replace_on, input logic grow_on);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ALLOW_REPLACE;
        cfg_data  <= replace_on;
        @(posedge clk);
        while (o_cfg_ready !== 1'b1) @(posedge clk);
        cfg_replace = replace_on;
        cfg_index <= CFG_ALLOW_GROW;
        cfg_data  <= grow_on;
        @(posedge clk);
        while (o_cfg_ready !== 1'b1) @(posedge clk);
        cfg_grow = grow_on;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_rules();
        send_item(make_section(1'b0, 8'hFF, 16'hFFFF, 5'd31, 8'd255, 8'd255));
        send_item(make_section(1'b1, 8'h01, 16'h0001, 5'd1, 8'd5, 8'd4));
        send_item(make_section(1'b1, 8'h00, 16'hFFFF, 5'd31, 8'd0, 8'd2));
        send_item(make_section(1'b1, 8'h01, 16'hFFFF, 5'd31, 8'd1, 8'd2));
        send_item(make_section(1'b1, 8'h00, 16'hFFFE, 5'd31, 8'd1, 8'd2));
        send_item(make_section(1'b1, 8'h00, 16'hFFFF, 5'd30, 8'd1, 8'd2));
        send_item(make_section(1'b1, 8'h00, 16'hFFFF, 5'd31, 8'd1, 8'd3));
        send_item(make_section(1'b1, 8'h00, 16'hFFFF, 5'd31, 8'd1, 8'd1));
        send_item(make_section(1'b1, 8'h00, 16'hFFFF, 5'd31, 8'd0, 8'd2));
        send_item(make_section(1'b1, 8'h00, 16'hFFFF, 5'd31, 8'd2, 8'd2));
        send_item(make_section(1'b1, 8'h00, 16'hFFFF, 5'd31, 8'd1, 8'd2));
        send_item(make_section(1'b1, 8'h00, 16'hFFFF, 5'd31, 8'd1, 8'd2));
        send_item(t_in'({1'b1, {($bits(t_in)-1){1'b1}}}));
        send_item(make_section(1'b1, 8'hFF, 16'h0000, 5'd0, 8'd255, 8'd255));
        send_item(make_section(1'b1, 8'hFF, 16'h0000, 5'd0, 8'd0, 8'd255));
        send_item(t_in'({1'b1, {($bits(t_in)-1){1'b0}}}));
    endtask

    task automatic test_grow();
        wait_idle();
        set_config(1'b0, 1'b1);
        send_item(make_section(1'b1, 8'h42, 16'h1234, 5'd7, 8'd0, 8'd1));
        send_item(make_section(1'b1, 8'h42, 16'h1234, 5'd7, 8'd0, 8'd3));
        send_item(make_section(1'b1, 8'h42, 16'h1234, 5'd7, 8'd1, 8'd0));
        send_item(make_section(1'b1, 8'h42, 16'h1234, 5'd7, 8'd3, 8'd3));
        send_item(make_section(1'b1, 8'h42, 16'h1234, 5'd7, 8'd2, 8'd3));
        send_item(make_section(1'b1, 8'h42, 16'h1234, 5'd7, 8'd5, 8'd6));
        send_item(random_item(1'b1));
    endtask

    task automatic test_replace();
        wait_idle();
        set_config(1'b1, 1'b0);
        send_item(make_section(1'b1, 8'h07, 16'h0007, 5'd3, 8'd0, 8'd0));
        send_item(make_section(1'b1, 8'h07, 16'h0007, 5'd3, 8'd0, 8'd0));
        send_item(make_section(1'b1, 8'h08, 16'h0007, 5'd3, 8'd0, 8'd0));
        send_item(random_item(1'b1));
    endtask

    task automatic test_output_stall();
        wait_idle();
        tx_idle = 1'b0;
        rx_hold = 400;
        send_item(random_item(1'b1));
        for (int k = 0; k < 16; k++)
            send_item(make_section(1'b1, 8'h5A, 16'hA5A5, 5'd9, 8'(k), 8'd15));
        for (int k = 0; k < 4; k++)
            send_item(make_section(1'b1, 8'h5A, 16'hA5A5, 5'd9, 8'(k), 8'd15));
        wait_idle();
        tx_idle = 1'b1;
    endtask

    task automatic run_episodes(input int count);
        int          sent;
        int          ep_size;
        int          ep_len;
        int          kind;
        int          sn;
        int          lsn;
        logic [7:0]  ep_tid;
        logic [15:0] ep_ext;
        logic [4:0]  ep_ver;
        t_in         it;
        sent = 0;
        while (sent < count) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            ep_size = ($urandom_range(0, 29) == 0) ? $urandom_range(128, 256)
                                                   : $urandom_range(1, 12);
            ep_len  = (3 * ep_size + 4 > 60) ? 60 : 3 * ep_size + 4;
            ep_tid  = 8'($urandom());
            ep_ext  = 16'($urandom());
            ep_ver  = 5'($urandom());
            for (int i = 0; i < ep_len && sent < count; i++) begin
                lsn  = (tbl_size != 9'd0) ? int'(tbl_size) - 1 : ep_size - 1;
                sn   = $urandom_range(0, lsn);
                kind = $urandom_range(0, 99);
                if ($urandom_range(0, 3) != 0)
                    for (int k = 0; k <= lsn; k++)
                        if (!tbl_present[(sn + k) % (lsn + 1)]) begin
                            sn = (sn + k) % (lsn + 1);
                            break;
                        end
                it = make_section(1'b1, ep_tid, ep_ext, ep_ver, 8'(sn), 8'(lsn));
                if (kind >= 60 && kind < 70) begin
                    lsn = $urandom_range(0, 255);
                    it.last_section_number = 8'(lsn);
                    it.section_number      = 8'($urandom_range(0, lsn));
                end else if (kind >= 70 && kind < 78) begin
                    case ($urandom_range(0, 2))
                        0:       it.table_id       ^= 8'($urandom_range(1, 255));
                        1:       it.table_id_ext   ^= 16'($urandom_range(1, 65535));
                        default: it.version_number ^= 5'($urandom_range(1, 31));
                    endcase
                end else if (kind >= 78 && kind < 84) begin
                    it.section_ok          = 1'b0;
                    it.section_number      = 8'($urandom());
                    it.last_section_number = 8'($urandom());
                end else if (kind >= 84 && kind < 89) begin
                    lsn = $urandom_range(0, 254);
                    it.last_section_number = 8'(lsn);
                    it.section_number      = 8'($urandom_range(lsn + 1, 255));
                end else if (kind >= 89 && kind < 96) begin
                    it = random_item(1'b0);
                end else if (kind >= 96) begin
                    it = random_item(1'b1);
                end
                send_item(it);
                sent++;
                if (tbl_complete && $urandom_range(0, 1) == 0)
                    break;
            end
            if ($urandom_range(0, 3) != 0 && sent < count) begin
                send_item(random_item(1'b1));
                sent++;
            end
        end
    endtask

    task automatic test_random();
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            set_config(p[0], p[1]);
            run_episodes(185);
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin
        int rx_gap;
        @(posedge clk);
        forever begin
            if (rx_hold > 0) begin
                rx_gap  = rx_hold;
                rx_hold = 0;
            end else begin
                rx_gap = rx_idle ? $urandom_range(0, 9) : 0;
            end
            if (rx_gap > 0) begin
                out_ready <= 1'b0;
                repeat (rx_gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (o_out_valid !== 1'b1) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid === 1'b1 && out_ready) begin
            if (verdict_q.size() == 0) begin
                if (n_fail < 10)
                    $display("unexpected result beat: %h", o_out_data);
                n_fail++;
            end else begin
                want = verdict_q.pop_front();
                if (o_out_data.accepted !== want.accepted ||
                    o_out_data.status !== want.status ||
                    o_out_data.table_complete !== want.table_complete ||
                    o_out_data.missing_sections !== want.missing_sections ||
                    o_out_data.table_last_section !== want.table_last_section ||
                    o_out_data.adjusted_last_section !== want.adjusted_last_section) begin
                    if (n_fail < 10) begin
                        $display("mismatch: want acc=%0d st=%0d cpl=%0d miss=%0d last=%0d adj=%0d",
                                 want.accepted, want.status, want.table_complete,
                                 want.missing_sections, want.table_last_section,
                                 want.adjusted_last_section);
                        $display("          got  acc=%0d st=%0d cpl=%0d miss=%0d last=%0d adj=%0d",
                                 o_out_data.accepted, o_out_data.status,
                                 o_out_data.table_complete, o_out_data.missing_sections,
                                 o_out_data.table_last_section,
                                 o_out_data.adjusted_last_section);
                    end
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        forget_table();
        cfg_replace = 1'b0;
        cfg_grow    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_rules();
        test_grow();
        test_replace();
        test_output_stall();
        test_random();
        wait_idle();
        repeat (10) @(posedge clk);
        if (n_fail == 0 && verdict_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
design/psita_pkg.sv
design/psita_core.sv
design/psi_table_section_assembler_top.sv
bench/psi_table_section_assembler_top_tb.sv
